FILE: design/eaq_pkg.sv
// package: types, constants and arctangent table for the euler to quaternion block
`default_nettype none
package eaq_pkg;
	localparam int Steps = 20;
	localparam logic signed [33:0] Gain = 34'sd652032874;
	localparam logic signed [33:0] Pi = 34'sd3373259426;
	localparam logic signed [33:0] HalfPi = 34'sd1686629713;
	localparam logic signed [15:0] QOne = 16'sd16384;

	typedef struct packed {
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] quat_scalar;
		logic signed [15:0] quat_i;
		logic signed [15:0] quat_j;
		logic signed [15:0] quat_k;
	} quat_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: atan_q30 = 34'sd843314856;
			5'd1: atan_q30 = 34'sd497837829;
			5'd2: atan_q30 = 34'sd263043836;
			5'd3: atan_q30 = 34'sd133525158;
			5'd4: atan_q30 = 34'sd67021686;
			5'd5: atan_q30 = 34'sd33543515;
			5'd6: atan_q30 = 34'sd16775850;
			5'd7: atan_q30 = 34'sd8388437;
			5'd8: atan_q30 = 34'sd4194282;
			5'd9: atan_q30 = 34'sd2097149;
			5'd10: atan_q30 = 34'sd1048575;
			5'd11: atan_q30 = 34'sd524287;
			5'd12: atan_q30 = 34'sd262143;
			5'd13: atan_q30 = 34'sd131071;
			5'd14: atan_q30 = 34'sd65535;
			5'd15: atan_q30 = 34'sd32767;
			5'd16: atan_q30 = 34'sd16383;
			5'd17: atan_q30 = 34'sd8191;
			5'd18: atan_q30 = 34'sd4095;
			5'd19: atan_q30 = 34'sd2047;
			default: atan_q30 = 34'sd0;
		endcase
	endfunction
endpackage
`default_nettype wire

FILE: design/eaq_cordic.sv
// pipelined cordic: cosine and sine of half an angle, each step registered
`default_nettype none
module eaq_cordic (
	input wire logic clk,
	input wire logic signed [15:0] ang,
	output logic signed [17:0] cos_q16,
	output logic signed [17:0] sin_q16
);
	import eaq_pkg::*;

	logic signed [33:0] x_s [0:Steps];
	logic signed [33:0] y_s [0:Steps];
	logic signed [33:0] z_s [0:Steps];
	logic flip_s [0:Steps];
	logic signed [33:0] zin;
	logic signed [33:0] xf, yf;

	assign zin = {{2{ang[15]}}, ang, 16'd0};

	always_ff @(posedge clk) begin
		if (zin > HalfPi) begin
			z_s[0] <= zin - Pi;
			flip_s[0] <= 1'b1;
		end else if (zin < -HalfPi) begin
			z_s[0] <= zin + Pi;
			flip_s[0] <= 1'b1;
		end else begin
			z_s[0] <= zin;
			flip_s[0] <= 1'b0;
		end
		x_s[0] <= Gain;
		y_s[0] <= '0;
	end

	for (genvar i = 0; i < Steps; i++) begin : g_step
		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
			if (!z_s[i][33]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_q30(5'(i));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_q30(5'(i));
			end
		end
	end

	assign xf = flip_s[Steps] ? -x_s[Steps] : x_s[Steps];
	assign yf = flip_s[Steps] ? -y_s[Steps] : y_s[Steps];

	logic signed [33:0] xr, yr;
	assign xr = (xf + 34'sd8192) >>> 14;
	assign yr = (yf + 34'sd8192) >>> 14;

	always_ff @(posedge clk) begin
		cos_q16 <= xr[17:0];
		sin_q16 <= yr[17:0];
	end
endmodule
`default_nettype wire

FILE: design/euler_angles_to_quaternion.sv
// top level: euler angles to unit quaternion, fully pipelined
//
// request channel: start with angles; taken when start is high and busy low.
// busy is always low, so a new request can enter in every clock cycle.
// result channel: done pulses for one cycle with quat; the receiver cannot
// stall and every result is shown exactly once.
// from the accepting edge to done, a request passes one fold stage, 20 cordic
// steps, one rounding stage, then two multiply stages, a sum stage and a round
// and clamp stage.
// throughput: one quaternion per cycle, set by the cordic step pipeline.
// reset clears the valid bits only; no request in flight survives reset.
`default_nettype none
module euler_angles_to_quaternion (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire eaq_pkg::angles_t angles,
	output logic done,
	output eaq_pkg::quat_t quat
);
	import eaq_pkg::*;

	localparam int Lat = Steps + 6;

	logic [Lat-1:0] vld_q;
	logic fire;
	logic signed [17:0] cr, sr, cp, sp, cy, sy;

	assign busy = 1'b0;
	assign fire = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Lat-2:0], fire};
	end

	eaq_cordic u_roll (.clk, .ang(angles.angle_z),
		.cos_q16(cr), .sin_q16(sr));
	eaq_cordic u_pitch (.clk, .ang(angles.angle_y),
		.cos_q16(cp), .sin_q16(sp));
	eaq_cordic u_yaw (.clk, .ang(angles.angle_x),
		.cos_q16(cy), .sin_q16(sy));

	// pair products of roll and pitch
	logic signed [35:0] cc_s1, ss_s1, sc_s1, cs_s1;
	logic signed [17:0] cy_s1, sy_s1;
	always_ff @(posedge clk) begin
		cc_s1 <= cr * cp;
		ss_s1 <= sr * sp;
		sc_s1 <= sr * cp;
		cs_s1 <= cr * sp;
		cy_s1 <= cy;
		sy_s1 <= sy;
	end

	logic signed [53:0] p_s2 [0:7];
	always_ff @(posedge clk) begin
		p_s2[0] <= cc_s1 * cy_s1;
		p_s2[1] <= ss_s1 * sy_s1;
		p_s2[2] <= sc_s1 * cy_s1;
		p_s2[3] <= cs_s1 * sy_s1;
		p_s2[4] <= cs_s1 * cy_s1;
		p_s2[5] <= sc_s1 * sy_s1;
		p_s2[6] <= cc_s1 * sy_s1;
		p_s2[7] <= ss_s1 * cy_s1;
	end

	logic signed [54:0] sum_s3 [0:3];
	always_ff @(posedge clk) begin
		sum_s3[0] <= 55'(p_s2[0]) + 55'(p_s2[1]) + (55'sd1 <<< 33);
		sum_s3[1] <= 55'(p_s2[2]) - 55'(p_s2[3]) + (55'sd1 <<< 33);
		sum_s3[2] <= 55'(p_s2[4]) + 55'(p_s2[5]) + (55'sd1 <<< 33);
		sum_s3[3] <= 55'(p_s2[6]) - 55'(p_s2[7]) + (55'sd1 <<< 33);
	end

	function automatic logic signed [15:0] clamp(input logic signed [54:0] v);
		logic signed [20:0] r;
		r = v[54:34];
		if (r > 21'sd16384) clamp = QOne;
		else if (r < -21'sd16384) clamp = -QOne;
		else clamp = r[15:0];
	endfunction

	always_ff @(posedge clk) begin
		quat.quat_scalar <= clamp(sum_s3[0]);
		quat.quat_i <= clamp(sum_s3[1]);
		quat.quat_j <= clamp(sum_s3[2]);
		quat.quat_k <= clamp(sum_s3[3]);
	end

	assign done = vld_q[Lat-1];

	a_never_busy: assert property (@(posedge clk) busy == 1'b0)
		else $error("busy raised");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_q[Lat-2]))
		else $error("result without request");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (quat.quat_scalar <= QOne && quat.quat_scalar >= -QOne))
		else $error("scalar out of range");
endmodule
`default_nettype wire

FILE: tb/sv/euler_angles_to_quaternion_test.sv
// testbench: euler angles to quaternion conversion against a bit-exact cordic predictor
`timescale 1ns / 100ps
`default_nettype none
module euler_angles_to_quaternion_test;
	import eaq_pkg::*;

	localparam int Latency = 27;
	localparam int WatchdogLimit = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	angles_t angles;
	logic done;
	quat_t quat;

	angles_t pending[$];
	quat_t expected_quats[$];
	int errors;
	int sent;
	int received;
	int idle_cycles;
	int gap;
	bit stim_done;
	bit hold_for_drain;

	euler_angles_to_quaternion uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.angles(angles),
		.done(done),
		.quat(quat)
	);

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic void half_trig(logic signed [15:0] ang, output longint c, output longint s);
		longint atans[20];
		longint z, x, y, dx, dy;
		bit flip;
		atans = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
			262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047};
		z = longint'(ang) * 65536;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 64'sd1686629713) begin
			z -= 64'sd3373259426;
			flip = 1;
		end else if (z < -64'sd1686629713) begin
			z += 64'sd3373259426;
			flip = 1;
		end
		for (int i = 0; i < 20; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atans[i];
			end else begin
				x += dx;
				y -= dy;
				z += atans[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = fshift(x + 8192, 14);
		s = fshift(y + 8192, 14);
	endfunction

	function automatic logic signed [15:0] round_clamp_q14(longint q48);
		longint r;
		r = fshift(q48 + (64'sd1 <<< 33), 34);
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return 16'(r);
	endfunction

	function automatic quat_t predict_quat(angles_t a);
		longint cr, sr, cp, sp, cy, sy;
		quat_t q;
		half_trig(a.angle_z, cr, sr);
		half_trig(a.angle_y, cp, sp);
		half_trig(a.angle_x, cy, sy);
		q.quat_scalar = round_clamp_q14(cr * cp * cy + sr * sp * sy);
		q.quat_i = round_clamp_q14(sr * cp * cy - cr * sp * sy);
		q.quat_j = round_clamp_q14(cr * sp * cy + sr * cp * sy);
		q.quat_k = round_clamp_q14(cr * cp * sy - sr * sp * cy);
		return q;
	endfunction

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 200)) - 16'sd100;
			2: return ($urandom_range(0, 1) ? 16'sd25736 : -16'sd25736) + 16'($urandom_range(0, 20)) - 16'sd10;
			default: return 16'($urandom_range(0, 51472)) - 16'sd25736;
		endcase
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 2) != 0)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 4);
	endfunction

	function automatic angles_t mk(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az);
		angles_t a;
		a.angle_x = ax;
		a.angle_y = ay;
		a.angle_z = az;
		return a;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		logic signed [15:0] edges[12];
		arst_n = 0;
		edges = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767, -16'sd32768, 16'sd12868,
			-16'sd12868, 16'sd12869, -16'sd12869, 16'sd1, -16'sd1, 16'sd25735};
		// directed: range ends, fold boundary around half angle pi/2, full 16-bit extremes
		for (int i = 0; i < 12; i++)
			pending.push_back(mk(edges[i], edges[(i + 3) % 12], edges[(i + 7) % 12]));
		pending.push_back(mk(16'sd32767, 16'sd32767, 16'sd32767));
		pending.push_back(mk(-16'sd32768, -16'sd32768, -16'sd32768));
		pending.push_back(mk(16'sd0, 16'sd25736, 16'sd0));
		pending.push_back(mk(16'sd12868, 16'sd12868, 16'sd12868));
		pending.push_back(mk(16'sh5555, 16'shAAAA, 16'sh5555));
		pending.push_back(mk(16'shAAAA, 16'sh5555, 16'shAAAA));
		for (int i = 0; i < 550; i++)
			pending.push_back(mk(rand_angle(), rand_angle(), rand_angle()));
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			angles <= '0;
			gap <= 0;
			hold_for_drain <= 0;
			stim_done <= 0;
		end else begin
			if (start && !busy) begin
				expected_quats.push_back(predict_quat(angles));
				sent <= sent + 1;
			end
			if (start && busy) begin
			end else if (hold_for_drain) begin
				start <= 0;
				if (expected_quats.size() == 0 && !(start && !busy))
					hold_for_drain <= 0;
			end else if (gap > 0) begin
				start <= 0;
				gap <= gap - 1;
			end else if (pending.size() > 0) begin
				start <= 1;
				angles <= pending.pop_front();
				if (pending.size() == 300)
					hold_for_drain <= 1;
				gap <= ($urandom_range(0, 200) == 0) ? 0 : rand_gap();
			end else begin
				start <= 0;
				stim_done <= 1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		quat_t want;
		int bad;
		bad = 0;
		if (arst_n && done) begin
			if (expected_quats.size() == 0) begin
				$error("unexpected result %h", quat);
				bad++;
			end else begin
				want = expected_quats.pop_front();
				if (quat.quat_scalar !== want.quat_scalar) begin
					$error("quat_scalar expected %0d actual %0d", want.quat_scalar, quat.quat_scalar);
					bad++;
				end
				if (quat.quat_i !== want.quat_i) begin
					$error("quat_i expected %0d actual %0d", want.quat_i, quat.quat_i);
					bad++;
				end
				if (quat.quat_j !== want.quat_j) begin
					$error("quat_j expected %0d actual %0d", want.quat_j, quat.quat_j);
					bad++;
				end
				if (quat.quat_k !== want.quat_k) begin
					$error("quat_k expected %0d actual %0d", want.quat_k, quat.quat_k);
					bad++;
				end
			end
			errors <= errors + bad;
			received <= received + 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		errors = 0;
		sent = 0;
		received = 0;
		idle_cycles = 0;
		wait (stim_done && expected_quats.size() == 0);
		repeat (Latency + 10) @(posedge clk);
		$display("requests sent %0d, quaternions checked %0d", sent, received);
		$display("covered range ends, fold boundaries and full 16-bit angle patterns");
		if (errors == 0 && expected_quats.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
